FILE: design/ife_pkg.sv
package ife_pkg;

  // Default frame limits
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Pixel and configuration port widths
  localparam int PIXEL_W    = 8;
  localparam int DIM_W      = 9;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 4;

  // Register reset values
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 9'd256;
  localparam logic             FLIP_DIR_RST     = 1'b0;

  // Register indexes (word address)
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_FLIP_DIR     = 2'd2,
    REG_NONE         = 2'd3
  } reg_index_t;

  // Item mode codes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Flip direction codes
  localparam logic FLIP_HORIZONTAL = 1'b0;
  localparam logic FLIP_VERTICAL   = 1'b1;

  // Result status codes
  localparam logic STATUS_OK         = 1'b0;
  localparam logic STATUS_NOT_LOADED = 1'b1;

  typedef struct packed {
    logic [PIXEL_W-1:0] red;
    logic [PIXEL_W-1:0] green;
    logic [PIXEL_W-1:0] blue;
  } rgb_t;

  // Configuration as seen by the control logic
  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic             flip_direction;
    logic             restart;
  } cfg_t;

  // Per-item information carried alongside the store read
  typedef struct packed {
    logic is_read;
    logic status;
    logic last;
  } meta_t;

endpackage

FILE: design/ife_if.sv
interface ife_in_if import ife_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               mode;
  logic [PIXEL_W-1:0] red_in;
  logic [PIXEL_W-1:0] green_in;
  logic [PIXEL_W-1:0] blue_in;

  modport source (output valid, mode, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface ife_out_if import ife_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] red_out;
  logic [PIXEL_W-1:0] green_out;
  logic [PIXEL_W-1:0] blue_out;
  logic               frame_last;
  logic               status;

  modport source (output valid, red_out, green_out, blue_out, frame_last, status,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, frame_last, status,
                  output ready);
endinterface

FILE: design/ife_cfg.sv
module ife_cfg import ife_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic             flip_direction;
  logic             restart;
  logic             wr_en;
  reg_index_t       idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= IMAGE_WIDTH_RST;
      image_height   <= IMAGE_HEIGHT_RST;
      flip_direction <= FLIP_DIR_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_IMAGE_WIDTH:  image_width    <= pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height   <= pwdata[DIM_W-1:0];
        REG_FLIP_DIR:     flip_direction <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Any write to a real register restarts the frame counters
  always_comb begin
    restart = 1'b0;
    if (wr_en) begin
      unique case (idx)
        REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_FLIP_DIR: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(image_height);
      REG_FLIP_DIR:     prdata = CFG_DATA_W'(flip_direction);
      default:          prdata = '0;
    endcase
  end

  assign cfg.image_width    = image_width;
  assign cfg.image_height   = image_height;
  assign cfg.flip_direction = flip_direction;
  assign cfg.restart        = restart;

endmodule

FILE: design/ife_ctrl.sv
module ife_ctrl import ife_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          fire,
  input  logic          mode,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic          rd_en,
  output logic [AW-1:0] rd_addr,
  output meta_t         meta
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int LW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam int SW = WW + HW;
  localparam int PW = LW + WW;

  logic [NW-1:0] write_count, write_count_next;
  logic [CW-1:0] read_column, read_column_next;
  logic [LW-1:0] read_line, read_line_next;

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [SW-1:0] frame_size;
  logic          loaded;
  logic          col_end;
  logic          line_end;
  logic [CW-1:0] x;
  logic [LW-1:0] y;
  logic [PW-1:0] line_base;
  logic [PW-1:0] addr_sum;

  // Out-of-range dimensions: zero acts as one, large values saturate
  always_comb begin
    if (cfg.image_width == '0) w = WW'(1);
    else if (32'(cfg.image_width) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(cfg.image_width);
    if (cfg.image_height == '0) h = HW'(1);
    else if (32'(cfg.image_height) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
    else h = HW'(cfg.image_height);
  end

  assign frame_size = SW'(w) * SW'(h);
  assign loaded     = SW'(write_count) >= frame_size;
  assign col_end    = WW'(read_column) == (w - WW'(1));
  assign line_end   = HW'(read_line) == (h - HW'(1));

  always_comb begin
    unique case (cfg.flip_direction)
      FLIP_HORIZONTAL: begin
        x = CW'(w - WW'(1) - WW'(read_column));
        y = read_line;
      end
      FLIP_VERTICAL: begin
        x = read_column;
        y = LW'(h - HW'(1) - HW'(read_line));
      end
      default: begin
        x = read_column;
        y = read_line;
      end
    endcase
  end

  assign line_base = PW'(y) * PW'(w);
  assign addr_sum  = line_base + PW'(x);
  assign rd_addr   = addr_sum[AW-1:0];
  assign wr_addr   = write_count[AW-1:0];

  assign wr_en = fire && (mode == MODE_WRITE) && !loaded;
  assign rd_en = fire && (mode == MODE_READ) && loaded;

  assign meta.is_read = (mode == MODE_READ);
  assign meta.status  = loaded ? STATUS_OK : STATUS_NOT_LOADED;
  assign meta.last    = loaded && col_end && line_end;

  always_comb begin
    write_count_next = write_count;
    read_column_next = read_column;
    read_line_next   = read_line;
    if (cfg.restart) begin
      write_count_next = '0;
      read_column_next = '0;
      read_line_next   = '0;
    end else if (wr_en) begin
      write_count_next = write_count + NW'(1);
    end else if (rd_en) begin
      priority if (col_end && line_end) begin
        write_count_next = '0;
        read_column_next = '0;
        read_line_next   = '0;
      end else if (col_end) begin
        read_column_next = '0;
        read_line_next   = read_line + LW'(1);
      end else begin
        read_column_next = read_column + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_count <= '0;
      read_column <= '0;
      read_line   <= '0;
    end else begin
      write_count <= write_count_next;
      read_column <= read_column_next;
      read_line   <= read_line_next;
    end
  end

endmodule

FILE: design/ife_store.sv
module ife_store import ife_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  rgb_t          wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output rgb_t          rd_data
);

  rgb_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

FILE: design/ife_out.sv
module ife_out import ife_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   fire,
  input  meta_t  meta,
  input  rgb_t   rd_data,
  output logic   in_ready,
  input  logic   out_ready,
  output logic   out_valid,
  output rgb_t   out_pixel,
  output logic   out_last,
  output logic   out_status
);

  logic s1_valid;
  logic s1_status;
  logic s1_last;
  logic s1_move;

  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fire) begin
      s1_valid <= meta.is_read;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_status <= meta.status;
      s1_last   <= meta.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_pixel  <= (s1_status == STATUS_NOT_LOADED) ? '0 : rd_data;
      out_last   <= s1_last;
      out_status <= s1_status;
    end
  end

endmodule

FILE: design/image_flip_engine.sv
// Channel   Dir  Modport           Payload
// pix_in    in   ife_in_if.sink    mode, red_in, green_in, blue_in
// pix_out   out  ife_out_if.source red_out, green_out, blue_out, frame_last, status
// apb       in   psel/penable/...  image_width @0x0, image_height @0x4,
//                                  flip_direction @0x8
//
// One item per clock on pix_in while pix_out keeps up, writes and reads alike; a
// read's pixel reaches pix_out through the store read register, then the output
// register. The frame store is a single-port-write, single-port-read memory
// of MAX_WIDTH*MAX_HEIGHT entries; one access per accepted item sets the rate.
// Reset (rst, synchronous) clears the counters, the pipeline valids and the
// registers; store contents stay undefined until written, no clearing pass.
// A stalled pix_out holds its result, the middle stage takes one more read,
// then pix_in.ready drops until pix_out frees up.
module image_flip_engine import ife_pkg::*; #(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  ife_in_if.sink                pix_in,
  ife_out_if.source             pix_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t          cfg;
  meta_t         meta;
  logic          fire;
  logic          wr_en;
  logic          rd_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  rgb_t          wr_data;
  rgb_t          rd_data;
  rgb_t          out_pixel;

  // Input transfer
  assign fire = pix_in.valid && pix_in.ready;

  assign wr_data.red   = pix_in.red_in;
  assign wr_data.green = pix_in.green_in;
  assign wr_data.blue  = pix_in.blue_in;

  // Register file on the APB port
  ife_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Load counter, read-out counters and mirrored address
  ife_ctrl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .fire    (fire),
    .mode    (pix_in.mode),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .meta    (meta)
  );

  // Frame store
  ife_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Result stage and output register, drives pix_in.ready
  ife_out u_out (
    .clk        (clk),
    .rst        (rst),
    .fire       (fire),
    .meta       (meta),
    .rd_data    (rd_data),
    .in_ready   (pix_in.ready),
    .out_ready  (pix_out.ready),
    .out_valid  (pix_out.valid),
    .out_pixel  (out_pixel),
    .out_last   (pix_out.frame_last),
    .out_status (pix_out.status)
  );

  assign pix_out.red_out   = out_pixel.red;
  assign pix_out.green_out = out_pixel.green;
  assign pix_out.blue_out  = out_pixel.blue;

endmodule

FILE: sim/flip_checker.sv
module flip_checker import ife_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  ife_in_if                     pix_in,
  ife_out_if                    pix_out,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output int                    not_loaded_seen
);

  typedef struct packed {
    rgb_t px;
    logic last;
    logic status;
  } mirrored_t;

  mirrored_t        expected_q[$];
  rgb_t             frame_copy [MAX_WIDTH_DEF*MAX_HEIGHT_DEF];
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;
  logic             cfg_flip;
  int unsigned      loaded_count;
  int unsigned      out_col;
  int unsigned      out_line;

  // 0 acts as 1, anything above the store limit acts as the limit
  function automatic int unsigned dim_used(input logic [DIM_W-1:0] v, input int unsigned lim);
    if (v == '0) return 1;
    if (v > lim) return lim;
    return 32'(v);
  endfunction

  task automatic restart_frame();
    loaded_count = 0;
    out_col      = 0;
    out_line     = 0;
  endtask

  task automatic report_fail(input string msg);
    $display("[%0t] flip_checker: %s", $time, msg);
    fail_count++;
  endtask

  task automatic compare_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) report_fail($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic predict_transfer(input logic m, input rgb_t px);
    int unsigned w;
    int unsigned h;
    int unsigned size;
    int unsigned x;
    int unsigned y;
    mirrored_t   r;
    w    = dim_used(cfg_width, MAX_WIDTH_DEF);
    h    = dim_used(cfg_height, MAX_HEIGHT_DEF);
    size = w * h;
    if (m == MODE_WRITE) begin
      // pixels past the end of the frame are dropped
      if (loaded_count < size) begin
        frame_copy[loaded_count] = px;
        loaded_count++;
      end
    end else if (loaded_count < size) begin
      r = '{px: '0, last: 1'b0, status: STATUS_NOT_LOADED};
      expected_q.push_back(r);
    end else begin
      if (cfg_flip == FLIP_HORIZONTAL) begin
        x = w - 1 - out_col;
        y = out_line;
      end else begin
        x = out_col;
        y = h - 1 - out_line;
      end
      r.px     = frame_copy[y * w + x];
      r.last   = (out_col == w - 1) && (out_line == h - 1);
      r.status = STATUS_OK;
      expected_q.push_back(r);
      if (r.last) begin
        restart_frame();
      end else if (out_col == w - 1) begin
        out_col = 0;
        out_line++;
      end else begin
        out_col++;
      end
    end
  endtask

  always @(posedge clk) begin
    mirrored_t want;
    if (rst) begin
      cfg_width       = IMAGE_WIDTH_RST;
      cfg_height      = IMAGE_HEIGHT_RST;
      cfg_flip        = FLIP_DIR_RST;
      restart_frame();
      expected_q.delete();
      fail_count      = 0;
      results_checked = 0;
      not_loaded_seen = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_index_t'(paddr[CFG_ADDR_W-1:2]))
          REG_IMAGE_WIDTH: begin
            cfg_width = pwdata[DIM_W-1:0];
            restart_frame();
          end
          REG_IMAGE_HEIGHT: begin
            cfg_height = pwdata[DIM_W-1:0];
            restart_frame();
          end
          REG_FLIP_DIR: begin
            cfg_flip = pwdata[0];
            restart_frame();
          end
          default: ;
        endcase
      end
      if (pix_out.valid && pix_out.ready) begin
        if (expected_q.size() == 0) begin
          report_fail($sformatf("result %0h/%0h/%0h with nothing pending",
                                pix_out.red_out, pix_out.green_out, pix_out.blue_out));
        end else begin
          want = expected_q.pop_front();
          compare_field("red", pix_out.red_out, want.px.red);
          compare_field("green", pix_out.green_out, want.px.green);
          compare_field("blue", pix_out.blue_out, want.px.blue);
          compare_field("frame_last", 8'(pix_out.frame_last), 8'(want.last));
          compare_field("status", 8'(pix_out.status), 8'(want.status));
          results_checked++;
          if (want.status == STATUS_NOT_LOADED) not_loaded_seen++;
        end
      end
      if (pix_in.valid && pix_in.ready) begin
        predict_transfer(pix_in.mode, '{red: pix_in.red_in, green: pix_in.green_in,
                                        blue: pix_in.blue_in});
      end
    end
    pending = expected_q.size();
  end

endmodule

FILE: sim/testbench.sv
module testbench;
  import ife_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 17;
  // let the read pipeline empty out before touching registers
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 1100;
  // at most about 2700 transfers, even with both sides stalling, plus register
  // traffic between frames
  localparam int CYCLE_LIMIT   = 200000;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic idle_on;      // random gaps on both channels
  int   items_sent;   // transfers that count toward the stimulus total
  int   cycle_count;
  int   fail_count;
  int   pending;
  int   results_checked;
  int   not_loaded_seen;

  ife_in_if  pix_in ();
  ife_out_if pix_out ();

  image_flip_engine uut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in),
    .pix_out (pix_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  flip_checker mirror_check (
    .clk             (clk),
    .rst             (rst),
    .pix_in          (pix_in),
    .pix_out         (pix_out),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .pready          (pready),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .not_loaded_seen (not_loaded_seen)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Hard stop if a handshake never completes
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Result side: drop ready at random while idling is enabled
  initial begin
    pix_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      pix_out.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end
  end

  function automatic rgb_t any_pixel();
    return rgb_t'(24'($urandom));
  endfunction

  // Mostly tiny frames; now and then a zero (acts as 1) or a medium size
  function automatic int unsigned pick_dim();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 4) return 0;
    if (roll < 12) return $urandom_range(9, 20);
    return $urandom_range(1, 8);
  endfunction

  // One pixel-channel transfer. Entered and left at a falling edge. Random
  // gaps come first; the payload is scrambled while valid is low.
  task automatic send_item(input logic m, input rgb_t px, input bit counted = 1'b1);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      pix_in.valid    <= 1'b0;
      pix_in.mode     <= 1'($urandom);
      pix_in.red_in   <= 8'($urandom);
      pix_in.green_in <= 8'($urandom);
      pix_in.blue_in  <= 8'($urandom);
      @(negedge clk);
    end
    pix_in.valid    <= 1'b1;
    pix_in.mode     <= m;
    pix_in.red_in   <= px.red;
    pix_in.green_in <= px.green;
    pix_in.blue_in  <= px.blue;
    @(posedge clk);
    while (!pix_in.ready) @(posedge clk);
    @(negedge clk);
    if (counted) items_sent++;
  endtask

  // Stop sending, let every pending result come out, then let the pipe settle
  // so a trailing pixel write has landed before any register write.
  task automatic drain();
    pix_in.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Setup cycle, access cycle, then the bus goes idle
  task automatic cfg_write(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  task automatic configure(input int unsigned w_reg, input int unsigned h_reg,
                           input logic flip);
    drain();
    cfg_write(REG_IMAGE_WIDTH, CFG_DATA_W'(w_reg));
    cfg_write(REG_IMAGE_HEIGHT, CFG_DATA_W'(h_reg));
    cfg_write(REG_FLIP_DIR, CFG_DATA_W'(flip));
  endtask

  // A frame (or two back to back) under one setting. Mostly a clean load and
  // full read-out; sometimes an early read while loading, writes past the
  // end, a read after the read-out wrapped, or a load / read-out cut short.
  task automatic run_frame(input int unsigned w_reg, input int unsigned h_reg,
                           input logic flip);
    int unsigned w;
    int unsigned h;
    int unsigned size;
    int unsigned k;
    w    = (w_reg == 0) ? 1 : ((w_reg > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w_reg);
    h    = (h_reg == 0) ? 1 : ((h_reg > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : h_reg);
    size = w * h;
    configure(w_reg, h_reg, flip);
    repeat (($urandom_range(99) < 25) ? 2 : 1) begin
      if ($urandom_range(99) < 5) begin
        repeat ($urandom_range(size - 1)) send_item(MODE_WRITE, any_pixel());
        return;
      end
      for (k = 0; k < size; k++) begin
        if ($urandom_range(99) < 4) send_item(MODE_READ, any_pixel());
        send_item(MODE_WRITE, any_pixel());
      end
      if ($urandom_range(99) < 10) begin
        repeat ($urandom_range(1, 3)) send_item(MODE_WRITE, any_pixel(), 1'b0);
      end
      if (size > 1 && $urandom_range(99) < 8) begin
        repeat ($urandom_range(1, size - 1)) send_item(MODE_READ, any_pixel());
        return;
      end
      repeat (size) send_item(MODE_READ, any_pixel());
      if ($urandom_range(99) < 15) send_item(MODE_READ, any_pixel());
    end
  endtask

  initial begin
    rst             = 1'b1;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    pix_in.valid    = 1'b0;
    pix_in.mode     = MODE_WRITE;
    pix_in.red_in   = '0;
    pix_in.green_in = '0;
    pix_in.blue_in  = '0;
    idle_on         = 1'b1;
    items_sent      = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed ---
    // Reset frame is 256x256: reads before it is loaded come back zero with
    // the not-loaded status, and do not move the read-out.
    send_item(MODE_READ, any_pixel());
    send_item(MODE_WRITE, rgb_t'(24'hFFFFFF));
    send_item(MODE_READ, any_pixel());

    // 2x2 horizontal mirror with extreme colors, one write past the end
    // (dropped), full read-out, then a read after the wrap.
    configure(2, 2, FLIP_HORIZONTAL);
    send_item(MODE_WRITE, rgb_t'(24'h000000));
    send_item(MODE_WRITE, rgb_t'(24'hFFFFFF));
    send_item(MODE_WRITE, rgb_t'(24'hFF00AA));
    send_item(MODE_WRITE, rgb_t'(24'h00FF55));
    send_item(MODE_WRITE, rgb_t'(24'h123456), 1'b0);
    repeat (4) send_item(MODE_READ, any_pixel());
    send_item(MODE_READ, any_pixel());

    // 2x2 vertical flip; a write to the unused register mid-load must not
    // restart the frame.
    drain();
    cfg_write(REG_FLIP_DIR, CFG_DATA_W'(FLIP_VERTICAL));
    send_item(MODE_WRITE, rgb_t'(24'hAA55AA));
    send_item(MODE_WRITE, rgb_t'(24'h55AA55));
    drain();
    cfg_write(REG_NONE, '0);
    send_item(MODE_WRITE, rgb_t'(24'h0F0F0F));
    send_item(MODE_WRITE, rgb_t'(24'hF0F0F0));
    repeat (4) send_item(MODE_READ, any_pixel());

    // --- random ---
    // Full-width line set by the register maximum, with no gaps on either
    // side, then the tallest frame with gaps on; both act as the store limits.
    idle_on = 1'b0;
    run_frame(511, 1, FLIP_HORIZONTAL);
    idle_on = 1'b1;
    run_frame(1, 511, FLIP_VERTICAL);

    while (items_sent < RANDOM_ITEMS) begin
      run_frame(pick_dim(), pick_dim(), 1'($urandom));
    end

    drain();
    $display("Covered %0d pixel transfers over frames from 1x1 up to 256 pixels per side,",
             items_sent);
    $display("%0d mirrored results checked, %0d of them not-loaded replies, in %0d cycles.",
             results_checked, not_loaded_seen, cycle_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
design/ife_pkg.sv
design/ife_if.sv
design/ife_cfg.sv
design/ife_ctrl.sv
design/ife_store.sv
design/ife_out.sv
design/image_flip_engine.sv
sim/flip_checker.sv
sim/testbench.sv
